// ===== src/signed_decimal_digit_display_writer_unit_assert.svh =====
// Assertion macros shared by the checker of the signed decimal digit display writer.
// Depends on nothing; the using module provides clk and arst_n.
`ifndef SIGNED_DECIMAL_DIGIT_DISPLAY_WRITER_UNIT_ASSERT_SVH
`define SIGNED_DECIMAL_DIGIT_DISPLAY_WRITER_UNIT_ASSERT_SVH

// check a property at every clock edge outside reset
`define SDDW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition leads to another in the next cycle
`define SDDW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sddw_pkg.sv =====
// Types and constants of the signed decimal digit display writer.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps

package sddw_pkg;

	localparam int NUMBER_W    = 15;
	localparam int MAG_W       = 14;
	localparam int REG_W       = 3;
	localparam int CODE_W      = 4;
	localparam int DIGIT_COUNT = 4;

	typedef logic [CODE_W-1:0]   code_t;
	typedef logic [REG_W-1:0]    digit_reg_t;
	typedef logic [NUMBER_W-1:0] number_t;

	localparam code_t CODE_MINUS = 4'hA;
	localparam code_t CODE_BLANK = 4'hF;

	localparam digit_reg_t REG_FIRST = 3'd1;
	localparam digit_reg_t REG_LAST  = 3'd4;

	localparam logic signed [NUMBER_W-1:0] MAX_SHOWN = 15'sd9999;
	localparam logic signed [NUMBER_W-1:0] MIN_SHOWN = -15'sd999;

endpackage

// ===== src/signed_decimal_digit_display_writer_unit.sv =====
// An accepted item waits in the input register until the writes of the previous item are done;
// then its codes move to the output register, and the four writes go out through the single output port;
// the input register takes the next item while the writes of the current one go out.
// Out-of-range items leave no write; they only pass through the input register.
// Reset (arst_n low, asynchronous) empties both registers; no writes pending afterwards.
`timescale 1ns / 1ps

module signed_decimal_digit_display_writer_unit
	import sddw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  number_t    number,
	output logic       out_valid,
	input  logic       out_stall,
	output digit_reg_t digit_register,
	output code_t      digit_code,
	output logic       last_write
);

	localparam int IDX_W = $clog2(DIGIT_COUNT);
	localparam int PROD_W = 28;
	localparam logic [PROD_W-1:0] RECIP10   = PROD_W'(6554);
	localparam logic [PROD_W-1:0] RECIP100  = PROD_W'(5243);
	localparam logic [PROD_W-1:0] RECIP1000 = PROD_W'(8389);
	localparam int SHIFT10   = 16;
	localparam int SHIFT100  = 19;
	localparam int SHIFT1000 = 23;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

	logic             valid_s1;
	number_t          number_s1;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	code_t            codes_q [DIGIT_COUNT];

	logic             out_fire;
	logic             out_free;
	logic             s1_move;
	logic             in_fire;
	logic             in_range;
	logic             negative;
	logic [MAG_W-1:0] mag;
	logic [PROD_W-1:0] p10, p100, p1000;
	logic [9:0]       q10;
	logic [6:0]       q100;
	logic [3:0]       q1000;
	code_t            d0, d1, d2, d3;
	code_t            codes [DIGIT_COUNT];

	assign out_fire = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || (out_fire && idx_q == IDX_LAST);
	assign s1_move  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		in_range = ($signed(number_s1) <= MAX_SHOWN) && ($signed(number_s1) >= MIN_SHOWN);
		negative = number_s1[NUMBER_W-1];
		mag      = negative ? MAG_W'(-number_s1) : MAG_W'(number_s1);

		p10   = PROD_W'(mag) * RECIP10;
		p100  = PROD_W'(mag) * RECIP100;
		p1000 = PROD_W'(mag) * RECIP1000;
		q10   = p10[SHIFT10 +: 10];
		q100  = p100[SHIFT100 +: 7];
		q1000 = p1000[SHIFT1000 +: 4];

		d0 = CODE_W'(mag - MAG_W'(MAG_W'(q10) * MAG_W'(10)));
		d1 = CODE_W'(q10 - 10'(10'(q100) * 10'd10));
		d2 = CODE_W'(q100 - 7'(7'(q1000) * 7'd10));
		d3 = q1000;

		codes[0] = d0;
		codes[1] = d1;
		codes[2] = d2;
		codes[3] = d3;
		if (negative) begin
			codes[3] = CODE_BLANK;
			if (d2 != '0) begin
				codes[3] = CODE_MINUS;
			end else if (d1 != '0) begin
				codes[2] = CODE_MINUS;
			end else begin
				codes[2] = CODE_BLANK;
				codes[1] = CODE_MINUS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= in_range;
				idx_q       <= '0;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end else if (out_fire) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			number_s1 <= number;
		end
		if (s1_move) begin
			codes_q <= codes;
		end
	end

	assign out_valid      = out_valid_q;
	assign digit_register = REG_W'(idx_q) + REG_FIRST;
	assign digit_code     = codes_q[idx_q];
	assign last_write     = (idx_q == IDX_LAST);

endmodule

// ===== src/sddw_checker.sv =====
// Port-level checker for the signed decimal digit display writer, bound to its top level.
// Depends on sddw_pkg and signed_decimal_digit_display_writer_unit_assert.svh.
`timescale 1ns / 1ps
`include "signed_decimal_digit_display_writer_unit_assert.svh"

module sddw_checker
	import sddw_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input number_t    number,
	input logic       out_valid,
	input logic       out_stall,
	input digit_reg_t digit_register,
	input code_t      digit_code,
	input logic       last_write
);

	`SDDW_ASSERT(a_last_on_top, !out_valid || (last_write == (digit_register == REG_LAST)), "last_write out of step with digit register")
	`SDDW_ASSERT_NEXT(a_reg_advance, out_valid && !out_stall && digit_register != REG_LAST, out_valid && digit_register == $past(digit_register) + REG_FIRST, "write run broken before the thousands digit")
	`SDDW_ASSERT(a_code_legal, !out_valid || digit_code <= CODE_MINUS || digit_code == CODE_BLANK, "digit code outside code-B set")
	`SDDW_ASSERT(a_minus_place, !out_valid || digit_code != CODE_MINUS || digit_register != REG_FIRST, "minus on the units digit")
	`SDDW_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(digit_register) && $stable(digit_code) && $stable(last_write), "stalled write changed")

endmodule

bind signed_decimal_digit_display_writer_unit sddw_checker u_sddw_checker (.*);

// ===== tb/digit_write_compare.sv =====
// Watches both item channels of the signed decimal digit display writer, predicts the four
// digit writes of each accepted in-range number and compares them in order. Depends on sddw_pkg.
`timescale 1ns / 1ps

module digit_write_compare
	import sddw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  number_t    number,
	input  logic       out_valid,
	input  logic       out_stall,
	input  digit_reg_t digit_register,
	input  code_t      digit_code,
	input  logic       last_write,
	output int         mismatch_count,
	output int         pending_writes
);

	typedef struct packed {
		digit_reg_t reg_addr;
		code_t      code;
		logic       last;
	} digit_write_t;

	localparam int REPORT_CAP = 40;

	digit_write_t expected_writes[$];

	initial begin
		mismatch_count = 0;
		pending_writes = 0;
	end

	function automatic void predict_digit_writes(input number_t num);
		int value;
		int mag;
		int top;
		int k;
		bit neg;
		code_t codes[DIGIT_COUNT];
		digit_write_t w;
		value = $signed(num);
		if (value > MAX_SHOWN || value < MIN_SHOWN)
			return;
		neg = value < 0;
		mag = neg ? -value : value;
		top = 0;
		for (k = 0; k < DIGIT_COUNT; k++) begin
			codes[k] = code_t'(mag % 10);
			if (codes[k] != 0)
				top = k;
			mag = mag / 10;
		end
		// blank above the top nonzero digit, minus right above it
		if (neg) begin
			for (k = top + 1; k < DIGIT_COUNT; k++)
				codes[k] = (k == top + 1) ? CODE_MINUS : CODE_BLANK;
		end
		for (k = 0; k < DIGIT_COUNT; k++) begin
			w.reg_addr = digit_reg_t'(REG_FIRST + k);
			w.code     = codes[k];
			w.last     = (k == DIGIT_COUNT - 1);
			expected_writes.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		digit_write_t want;
		if (arst_n) begin
			// compare first: a write never belongs to a number accepted at the same edge
			if (out_valid && !out_stall) begin
				if (expected_writes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP)
						$display("%0t: unexpected digit write: expected none, actual reg %0d code %0d last %0b",
							$time, digit_register, digit_code, last_write);
				end else begin
					want = expected_writes.pop_front();
					if (want.reg_addr !== digit_register || want.code !== digit_code
							|| want.last !== last_write) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_CAP)
							$display("%0t: digit write mismatch: expected reg %0d code %0d last %0b, actual reg %0d code %0d last %0b",
								$time, want.reg_addr, want.code, want.last,
								digit_register, digit_code, last_write);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_digit_writes(number);
			pending_writes <= expected_writes.size();
		end
	end

endmodule

// ===== tb/signed_decimal_digit_display_writer_unit_test.sv =====
// Top of the testbench for the signed decimal digit display writer: clock, reset, number items
// and output stalls, plus the verdict. Depends on sddw_pkg, the unit and digit_write_compare.
`timescale 1ns / 1ps

module signed_decimal_digit_display_writer_unit_test;
	import sddw_pkg::*;

	localparam int LONG_HOLD = 80;
	localparam int DIRECTED_COUNT = 25;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	number_t    number;
	logic       out_valid;
	logic       out_stall;
	digit_reg_t digit_register;
	code_t      digit_code;
	logic       last_write;
	int         mismatch_count;
	int         pending_writes;

	bit send_gaps;
	bit recv_gaps;
	bit hold_request;

	always #5 clk = ~clk;

	signed_decimal_digit_display_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.number(number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digit_register(digit_register),
		.digit_code(digit_code),
		.last_write(last_write)
	);

	digit_write_compare compare (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.number(number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digit_register(digit_register),
		.digit_code(digit_code),
		.last_write(last_write),
		.mismatch_count(mismatch_count),
		.pending_writes(pending_writes)
	);

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stall bursts, or one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer_number(input int value);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		number   <= number_t'(value);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_writes_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
	endtask

	function automatic int zero_heavy_digit();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic int random_display_number();
		int pick;
		int mag;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom_range(0, 9999);
		if (pick < 7) begin
			mag = zero_heavy_digit() * 100 + zero_heavy_digit() * 10 + zero_heavy_digit();
			if (mag == 0)
				mag = $urandom_range(1, 999);
			return -mag;
		end
		if (pick < 9)
			return zero_heavy_digit() * 1000 + zero_heavy_digit() * 100
				+ zero_heavy_digit() * 10 + zero_heavy_digit();
		// raw 15-bit pattern, mostly out of range
		return $signed(number_t'($urandom_range(0, 32767)));
	endfunction

	task automatic run_random(input int count);
		repeat (count)
			offer_number(random_display_number());
	endtask

	initial begin
		static int directed_values[DIRECTED_COUNT] = '{0, 9999, -999, -1, -1000, 10000, -16384,
			16383, 1, 9, 10, -10, -502, -50, -5, -100, -909, -90, -99, 1000, 1234, 8080, 5000,
			7, -1001};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		number       = '0;
		send_gaps    = 1'b0;
		recv_gaps    = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			offer_number(directed_values[i]);
		wait_writes_drained();

		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		run_random(60);
		hold_request = 1'b1;
		run_random(70);
		wait_writes_drained();

		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		run_random(120);

		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		run_random(100);

		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		run_random(50);

		wait_writes_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_writes == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
